FILE: hdl/sabf_pkg.sv
// shared types and constants for the slot allocator with bump counter and free list
package sabf_pkg;

   localparam int NUM_SLOTS_DEF = 256;
   localparam int SLOT_W        = 8;
   localparam int CNT_W         = 9;
   localparam int MAX_POOL      = 256;

   localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(MAX_POOL);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [SLOT_W-1:0] slot_in;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot_out;
      logic              full_res;
      logic              empty_res;
   } rsp_type;

   // write command into the link memory
   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] addr;
      logic [SLOT_W-1:0] data;
   } link_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

FILE: hdl/sabf_link_ram.sv
// single-port-write, registered-read memory holding the free list links
module sabf_link_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                           clock,
   input  sabf_pkg::link_wr_type          wr,
   input  logic [AW-1:0]                  rd_addr,
   output logic [sabf_pkg::SLOT_W-1:0]    rd_data
);
   import sabf_pkg::*;

   logic [SLOT_W-1:0] link_mem [DEPTH];
   logic [SLOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         link_mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= link_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/slot_allocator_bump_freelist_top.sv
// top level of the slot allocator: bump counter plus linked free list in memory
// a transferred request is held in req_ff for the execute state; its result is registered in rsp_ff and rsp_strobe_ff
// a new request is taken only in idle, never while busy; busy is high for the one execute cycle
// the return to idle between requests is set by the registered read of the link memory at the list head
// reset: synchronous, clears the counters, list head and pool size (to 256); links stay undefined
// the receiver cannot stall: each result is shown for exactly one cycle
module slot_allocator_bump_freelist_top #(
   parameter int NUM_SLOTS = sabf_pkg::NUM_SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  sabf_pkg::req_type            req_payload,
   output logic                         rsp_strobe,
   output sabf_pkg::rsp_type            rsp_payload,
   input  logic                         csr_we,
   input  logic [sabf_pkg::CNT_W-1:0]   csr_wdata
);
   import sabf_pkg::*;

   // links only exist for slots an index can reach
   localparam int DEPTH = (NUM_SLOTS > MAX_POOL) ? MAX_POOL : NUM_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(DEPTH);

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  slot_count_ff;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]  free_len_ff, free_len_in;
   logic [CNT_W-1:0]  bump_ff, bump_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic [CNT_W-1:0]  limit;
   logic [CNT_W-1:0]  slot_ext;
   logic [SLOT_W-1:0] link_rd;
   link_wr_type       link_wr;
   logic              ok_c;
   logic [SLOT_W-1:0] got_c;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff == ST_EXEC);

   // effective pool size, clamped to the link memory depth
   assign limit    = (slot_count_ff < CAP) ? slot_count_ff : CAP;
   assign slot_ext = {1'b0, req_ff.slot_in};

   // link memory is read at the list head every cycle; the head and the memory
   // only change at the end of the execute cycle, so the data in EXEC is current
   sabf_link_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd_addr (free_head_ff[AW-1:0]),
      .rd_data (link_rd)
   );

   // request execution, one item in the execute cycle
   always_comb begin
      free_head_in = free_head_ff;
      free_len_in  = free_len_ff;
      bump_in      = bump_ff;
      ok_c         = 1'b0;
      got_c        = '0;
      link_wr      = '0;
      if (busy) begin
         if (req_ff.opcode == OP_ALLOC) begin
            if (free_len_ff != '0) begin
               // pop the free list head
               ok_c         = 1'b1;
               got_c        = free_head_ff;
               free_head_in = link_rd;
               free_len_in  = free_len_ff - CNT_W'(1);
            end else if (bump_ff < limit) begin
               // hand out a never-used slot
               ok_c    = 1'b1;
               got_c   = bump_ff[SLOT_W-1:0];
               bump_in = bump_ff + CNT_W'(1);
            end
         end else begin
            if (slot_ext < limit) begin
               ok_c = 1'b1;
               if ((bump_ff != '0) && (slot_ext == (bump_ff - CNT_W'(1)))) begin
                  // last bumped slot comes back: roll the counter back
                  bump_in = bump_ff - CNT_W'(1);
               end else begin
                  // push onto the free list
                  link_wr.we   = 1'b1;
                  link_wr.addr = req_ff.slot_in;
                  link_wr.data = free_head_ff;
                  free_head_in = req_ff.slot_in;
                  free_len_in  = free_len_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   // result with status taken after the update
   always_comb begin
      rsp_in.ok        = ok_c;
      rsp_in.slot_out  = got_c;
      rsp_in.full_res  = (bump_in >= limit) && (free_len_in == '0);
      rsp_in.empty_res = (bump_in == free_len_in);
      rsp_strobe_in    = busy;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_count_ff <= SLOT_COUNT_RST;
         free_head_ff  <= '0;
         free_len_ff   <= '0;
         bump_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_len_ff   <= free_len_in;
         bump_ff       <= bump_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            slot_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // execute lasts exactly one cycle
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("execute cycle did not end");

   // every execute cycle gives one result strobe, and only then
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("missing result strobe after execute");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without execute");

   // a failed request never returns a slot index
   a_fail_zero_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.ok) |-> (rsp_payload.slot_out == '0))
      else $error("nonzero slot on failed request");

   // bump counter never passes the memory depth
   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= CAP)
      else $error("bump counter beyond pool capacity");

   // a rejected request leaves the allocator state untouched
   a_reject_stable: assert property (@(posedge clock) disable iff (reset)
      (busy && !ok_c) |=> ($stable(free_head_ff) && $stable(free_len_ff) && $stable(bump_ff)))
      else $error("state changed on rejected request");

endmodule
